// ----- design/lcte_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lcte_pkg;

  // One frame byte and the captured length of its frame.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [11:0] frame_length;
  } in_t;

  // One result: text marker, text byte or end-of-frame report.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  text_field;
    logic [7:0]  text_length;
    logic [7:0]  char_index;
    logic [7:0]  char_value;
    logic [1:0]  protocol;
    logic [15:0] vlan_id;
    logic [15:0] voice_vlan;
    logic        last_of_run;
  } out_t;

  // Results caused by one accepted byte, at most two.
  typedef struct packed {
    logic [1:0] count;
    out_t       res0;
    out_t       res1;
  } step_res_t;

  // Result kinds.
  localparam logic [1:0] KIND_MARK   = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  // Text fields.
  localparam logic [1:0] FLD_SYS_NAME  = 2'd0;
  localparam logic [1:0] FLD_PORT_ID   = 2'd1;
  localparam logic [1:0] FLD_SYS_DESC  = 2'd2;
  localparam logic [1:0] FLD_VLAN_NAME = 2'd3;

  // Frame classes, also the reported protocol.
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_LLDP = 2'd1;
  localparam logic [1:0] CLS_CDP  = 2'd2;

  // Walk phases.
  typedef enum logic [2:0] {
    PH_AREA  = 3'b001,
    PH_HEAD  = 3'b010,
    PH_VALUE = 3'b100
  } phase_t;

  localparam logic [7:0]  ETH_TYPE_HI   = 8'h88;
  localparam logic [7:0]  ETH_TYPE_LO   = 8'hCC;
  localparam logic [23:0] OUI_8021      = 24'h0080C2;
  localparam logic [23:0] OUI_TIA       = 24'h0012BB;
  localparam logic [15:0] CDP_NATIVE    = 16'h000A;
  localparam logic [15:0] CDP_VOICE     = 16'h000E;
  localparam logic [15:0] LLDP_ORG_TYPE = 16'd127;
  localparam logic [11:0] LLDP_START    = 12'd14;
  localparam logic [11:0] CDP_START     = 12'd26;

  // Destination address of CDP frames, one byte per position.
  function automatic logic [7:0] cdp_mac_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h01;
      3'd1:    v = 8'h00;
      3'd2:    v = 8'h0C;
      default: v = 8'hCC;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- design/lcte_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcte_step #(
  parameter int MAX_FRAME_BYTES = 2048,
  parameter int NAME_BYTES      = 128,
  parameter int DESC_BYTES      = 256,
  parameter int VLAN_NAME_BYTES = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire lcte_pkg::in_t         step_in,
  output lcte_pkg::step_res_t        step_res
);

  logic [11:0] pos_r, pos_nxt, len_r, len_nxt, toff_r, toff_nxt;
  logic [1:0]  cls_r, cls_nxt, tsel_r, tsel_nxt;
  logic        macm_r, macm_nxt, stop_r, stop_nxt, tact_r, tact_nxt;
  lcte_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] ttype_r, ttype_nxt, tlen_r, tlen_nxt, rec_r, rec_nxt;
  logic [15:0] vlan_r, vlan_nxt, vvlan_r, vvlan_nxt;
  logic [23:0] org_r, org_nxt;
  logic [7:0]  osub_r, osub_nxt, held_r, held_nxt;
  logic [7:0]  tcnt_r, tcnt_nxt, ttl_r, ttl_nxt;
  logic [2:0]  tfirst_r, tfirst_nxt;

  function automatic lcte_pkg::out_t mk(input logic [1:0] kind, input logic [1:0] fld,
                                        input logic [7:0] tl, input logic [7:0] idx,
                                        input logic [7:0] ch, input logic [1:0] proto,
                                        input logic [15:0] v, input logic [15:0] vv);
    lcte_pkg::out_t o;
    o.result_kind   = kind;
    o.text_field    = fld;
    o.text_length   = tl;
    o.char_index    = idx;
    o.char_value    = ch;
    o.protocol      = proto;
    o.vlan_id       = v;
    o.voice_vlan    = vv;
    o.last_of_run   = 1'b0;
    return o;
  endfunction

  // Cut a text length to one less than its buffer size.
  function automatic logic [7:0] clip(input logic [15:0] x, input int size);
    logic [7:0] c;
    if (32'(x) < size) c = x[7:0];
    else c = 8'(size - 1);
    return c;
  endfunction

  // Next state and results for the byte at the input.
  always_comb begin
    logic [7:0]  b;
    logic [11:0] p, rem;
    logic [8:0]  llen;
    logic [15:0] clen, n, k16;
    logic        have_text;
    logic [1:0]  hsel, proto;
    logic [7:0]  htl;
    logic [2:0]  hfirst;
    logic [12:0] koff;
    logic [8:0]  cnt1;
    lcte_pkg::out_t r0, r1, e;
    logic [1:0]  nres;
    logic        emit_e;

    b = step_in.data_byte;
    pos_nxt = pos_r;   len_nxt = len_r;     toff_nxt = toff_r;  cls_nxt = cls_r;
    tsel_nxt = tsel_r; macm_nxt = macm_r;   stop_nxt = stop_r;  tact_nxt = tact_r;
    phase_nxt = phase_r; ttype_nxt = ttype_r; tlen_nxt = tlen_r; rec_nxt = rec_r;
    vlan_nxt = vlan_r; vvlan_nxt = vvlan_r; org_nxt = org_r;    osub_nxt = osub_r;
    held_nxt = held_r; tcnt_nxt = tcnt_r;   ttl_nxt = ttl_r;    tfirst_nxt = tfirst_r;
    r0 = '0; r1 = '0; nres = 2'd0; e = '0; emit_e = 1'b0;
    llen = '0; clen = '0; n = '0; k16 = '0; koff = '0; cnt1 = '0;
    have_text = 1'b0; hsel = '0; htl = '0; hfirst = '0; proto = '0;

    // The first byte of a frame clears per-frame state and latches the length.
    if (pos_r == 12'd0) begin
      toff_nxt = '0; cls_nxt = lcte_pkg::CLS_NONE; tsel_nxt = '0; macm_nxt = 1'b1;
      stop_nxt = 1'b0; tact_nxt = 1'b0; phase_nxt = lcte_pkg::PH_AREA;
      ttype_nxt = '0; tlen_nxt = '0; rec_nxt = '0; vlan_nxt = '0; vvlan_nxt = '0;
      org_nxt = '0; osub_nxt = '0; held_nxt = '0; tcnt_nxt = '0; ttl_nxt = '0;
      tfirst_nxt = '0;
      if (step_in.frame_length == 12'd0) len_nxt = 12'd1;
      else if (32'(step_in.frame_length) > MAX_FRAME_BYTES)
        len_nxt = 12'(MAX_FRAME_BYTES);
      else len_nxt = step_in.frame_length;
    end
    p = pos_r;
    rem = len_nxt - p - 12'd1;

    // Address match and EtherType classification.
    if (p < 12'd6 && b != lcte_pkg::cdp_mac_byte(p[2:0])) macm_nxt = 1'b0;
    if (p == 12'd12) held_nxt = b;
    if (p == 12'd13) begin
      if (held_nxt == lcte_pkg::ETH_TYPE_HI && b == lcte_pkg::ETH_TYPE_LO)
        cls_nxt = lcte_pkg::CLS_LLDP;
      else cls_nxt = macm_nxt ? lcte_pkg::CLS_CDP : lcte_pkg::CLS_NONE;
    end

    // TLV walk.
    if (!stop_nxt && cls_nxt != lcte_pkg::CLS_NONE) begin
      if (phase_nxt == lcte_pkg::PH_AREA &&
          ((cls_nxt == lcte_pkg::CLS_LLDP && p == lcte_pkg::LLDP_START) ||
           (cls_nxt == lcte_pkg::CLS_CDP && p == lcte_pkg::CDP_START))) begin
        phase_nxt = lcte_pkg::PH_HEAD;
        toff_nxt = '0;
      end
      unique case (phase_nxt)
        lcte_pkg::PH_AREA: begin
        end
        lcte_pkg::PH_HEAD: begin
          // Header bytes: finish with the value length in n when complete.
          if (cls_nxt == lcte_pkg::CLS_LLDP) begin
            if (toff_nxt == 12'd0) begin
              if (rem <= 12'd1) stop_nxt = 1'b1;
              else begin
                held_nxt = b; toff_nxt = 12'd1;
              end
            end else begin
              llen = {held_nxt[0], b};
              ttype_nxt = {9'd0, held_nxt[7:1]};
              if ({3'd0, llen} > rem || held_nxt[7:1] == 7'd0) stop_nxt = 1'b1;
              else begin
                n = {7'd0, llen};
                if (held_nxt[7:1] == 7'd2) begin
                  have_text = 1'b1; hsel = lcte_pkg::FLD_PORT_ID;
                  htl = clip((n > 16'd1) ? n - 16'd1 : 16'd0, NAME_BYTES); hfirst = 3'd1;
                end else if (held_nxt[7:1] == 7'd5) begin
                  have_text = 1'b1; hsel = lcte_pkg::FLD_SYS_NAME;
                  htl = clip(n, NAME_BYTES);
                end else if (held_nxt[7:1] == 7'd6) begin
                  have_text = 1'b1; hsel = lcte_pkg::FLD_SYS_DESC;
                  htl = clip(n, DESC_BYTES);
                end
                tlen_nxt = n; toff_nxt = '0; org_nxt = '0; osub_nxt = '0; tact_nxt = 1'b0;
                phase_nxt = (n == 16'd0) ? lcte_pkg::PH_HEAD : lcte_pkg::PH_VALUE;
              end
            end
          end else begin
            case (toff_nxt[1:0])
              2'd0: begin
                if (rem < 12'd3) stop_nxt = 1'b1;
                else begin
                  ttype_nxt = {8'd0, b}; toff_nxt = 12'd1;
                end
              end
              2'd1: begin
                ttype_nxt = {ttype_nxt[7:0], b}; toff_nxt = 12'd2;
              end
              2'd2: begin
                tlen_nxt = {8'd0, b}; toff_nxt = 12'd3;
              end
              default: begin
                clen = {tlen_nxt[7:0], b};
                if (clen < 16'd4 || (clen - 16'd4) > {4'd0, rem}) stop_nxt = 1'b1;
                else begin
                  n = clen - 16'd4;
                  if (ttype_nxt == 16'd1) begin
                    have_text = 1'b1; hsel = lcte_pkg::FLD_SYS_NAME;
                    htl = clip(n, NAME_BYTES);
                  end else if (ttype_nxt == 16'd3) begin
                    have_text = 1'b1; hsel = lcte_pkg::FLD_PORT_ID;
                    htl = clip(n, NAME_BYTES);
                  end else if (ttype_nxt == 16'd5) begin
                    have_text = 1'b1; hsel = lcte_pkg::FLD_SYS_DESC;
                    htl = clip(n, DESC_BYTES);
                  end
                  tlen_nxt = n; toff_nxt = '0; org_nxt = '0; osub_nxt = '0; tact_nxt = 1'b0;
                  phase_nxt = (n == 16'd0) ? lcte_pkg::PH_HEAD : lcte_pkg::PH_VALUE;
                end
              end
            endcase
          end
        end
        lcte_pkg::PH_VALUE: begin
          // Value bytes: VLAN capture, organizational TLVs and text copy.
          n = tlen_nxt;
          k16 = {4'd0, toff_nxt};
          rec_nxt = {rec_nxt[7:0], b};
          if (cls_nxt == lcte_pkg::CLS_LLDP) begin
            if (ttype_nxt == lcte_pkg::LLDP_ORG_TYPE) begin
              if (k16 < 16'd3) org_nxt = {org_nxt[15:0], b};
              else if (k16 == 16'd3) begin
                osub_nxt = b;
                if (org_nxt == lcte_pkg::OUI_8021 && b == 8'd3 && n >= 16'd7 &&
                    32'(n - 16'd6) < VLAN_NAME_BYTES) begin
                  have_text = 1'b1; hsel = lcte_pkg::FLD_VLAN_NAME;
                  htl = 8'(n - 16'd6); hfirst = 3'd6;
                end
              end
              if (org_nxt == lcte_pkg::OUI_8021 && k16 == 16'd5 &&
                  ((osub_nxt == 8'd1 && n >= 16'd6) || (osub_nxt == 8'd3 && n >= 16'd7)))
                vlan_nxt = rec_nxt;
              if (org_nxt == lcte_pkg::OUI_TIA && osub_nxt == 8'd2 && n >= 16'd7 &&
                  k16 == 16'd6)
                vvlan_nxt = {7'd0, rec_nxt[8], b};
            end
          end else begin
            if (ttype_nxt == lcte_pkg::CDP_NATIVE && n >= 16'd2 && k16 == 16'd1)
              vlan_nxt = rec_nxt;
            if (ttype_nxt == lcte_pkg::CDP_VOICE && n >= 16'd3 && k16 == n - 16'd1)
              vvlan_nxt = rec_nxt;
          end
          if (tact_nxt && k16 >= {13'd0, tfirst_nxt}) begin
            emit_e = 1'b1;
            e = mk(lcte_pkg::KIND_CHAR, tsel_nxt, 8'd0, tcnt_nxt, b, 2'd0, 16'd0, 16'd0);
            cnt1 = {1'b0, tcnt_nxt} + 9'd1;
            tcnt_nxt = cnt1[7:0];
            if (cnt1 >= {1'b0, ttl_nxt}) tact_nxt = 1'b0;
          end
          koff = {1'b0, toff_nxt} + 13'd1;
          toff_nxt = koff[11:0];
          if ({3'd0, koff} >= n) begin
            phase_nxt = lcte_pkg::PH_HEAD; toff_nxt = '0; tact_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    // A text that starts on this byte gives a marker.
    if (have_text) begin
      tsel_nxt = hsel; ttl_nxt = htl; tfirst_nxt = hfirst;
      tcnt_nxt = '0; tact_nxt = (htl != 8'd0);
      emit_e = 1'b1;
      e = mk(lcte_pkg::KIND_MARK, hsel, htl, 8'd0, 8'd0, 2'd0, 16'd0, 16'd0);
    end
    if (emit_e) begin
      r0 = e; nres = 2'd1;
    end

    // End of frame report.
    if ({1'b0, p} + 13'd1 >= {1'b0, len_nxt}) begin
      proto = cls_nxt;
      if (len_nxt <= 12'd14 || (cls_nxt == lcte_pkg::CLS_CDP && len_nxt <= 12'd26))
        proto = lcte_pkg::CLS_NONE;
      e = mk(lcte_pkg::KIND_REPORT, 2'd0, 8'd0, 8'd0, 8'd0, proto,
             (proto != lcte_pkg::CLS_NONE) ? vlan_nxt : 16'd0,
             (proto != lcte_pkg::CLS_NONE) ? vvlan_nxt : 16'd0);
      e.last_of_run = 1'b1;
      if (nres == 2'd0) r0 = e;
      else r1 = e;
      nres = nres + 2'd1;
      pos_nxt = '0;
    end else begin
      pos_nxt = p + 12'd1;
      r0.last_of_run = (nres == 2'd1);
    end

    step_res.count = nres;
    step_res.res0 = r0;
    step_res.res1 = r1;
  end

  // Walk state; payload-like registers update without reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; len_r <= '0; cls_r <= lcte_pkg::CLS_NONE; macm_r <= 1'b1;
      stop_r <= 1'b0; tact_r <= 1'b0; phase_r <= lcte_pkg::PH_AREA; toff_r <= '0;
    end else if (step_en) begin
      pos_r <= pos_nxt; len_r <= len_nxt; cls_r <= cls_nxt; macm_r <= macm_nxt;
      stop_r <= stop_nxt; tact_r <= tact_nxt; phase_r <= phase_nxt; toff_r <= toff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      tsel_r <= tsel_nxt; ttype_r <= ttype_nxt; tlen_r <= tlen_nxt; rec_r <= rec_nxt;
      vlan_r <= vlan_nxt; vvlan_r <= vvlan_nxt; org_r <= org_nxt; osub_r <= osub_nxt;
      held_r <= held_nxt; tcnt_r <= tcnt_nxt; ttl_r <= ttl_nxt; tfirst_r <= tfirst_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/lcte_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcte_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire lcte_pkg::step_res_t push_res,
  input  wire logic                pop,
  output lcte_pkg::out_t           head,
  output logic                     not_empty,
  output logic                     room2
);

  lcte_pkg::out_t ent_r [4];
  logic [1:0] rd_r, rd_nxt, wr_r, wr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] push_n;

  assign push_n    = push ? push_res.count : 2'd0;
  assign head      = ent_r[rd_r];
  assign not_empty = (cnt_r != 3'd0);
  assign room2     = (cnt_r <= 3'd2);

  // Pointer and fill count.
  always_comb begin
    wr_nxt  = wr_r + push_n;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push_n} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      rd_r <= rd_nxt; wr_r <= wr_nxt; cnt_r <= cnt_nxt;
    end
  end

  // Up to two entries are written per request.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) ent_r[wr_r] <= push_res.res0;
    if (push_n == 2'd2) ent_r[wr_r + 2'd1] <= push_res.res1;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("queue fill count above depth");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> (cnt_r <= 3'd2))
    else $error("push without room for two results");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    ((wr_r - rd_r) == cnt_r[1:0]))
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

// ----- design/lldp_cdp_tlv_extractor_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// LLDP/CDP neighbor extractor. Feed one frame byte per request with the frame's
// captured length; the block accepts a byte every cycle, updating its TLV walk in a
// single registered step, and queues the results (text markers, text bytes and one
// end-of-frame report) in a four-entry output queue. Each byte yields at most two
// results, so input ready drops only when the queue holds more than two results,
// which happens when the result side stalls. The results of a byte are registered
// into the queue as the byte is accepted.
module lldp_cdp_tlv_extractor_core #(
  parameter int MAX_FRAME_BYTES = 2048,
  parameter int NAME_BYTES      = 128,
  parameter int DESC_BYTES      = 256,
  parameter int VLAN_NAME_BYTES = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lcte_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lcte_pkg::out_t      out_data
);

  logic                take;
  lcte_pkg::step_res_t res;

  assign take = in_valid && in_ready;

  lcte_step #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .NAME_BYTES     (NAME_BYTES),
    .DESC_BYTES     (DESC_BYTES),
    .VLAN_NAME_BYTES(VLAN_NAME_BYTES)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (take),
    .step_in (in_data),
    .step_res(res)
  );

  lcte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (take),
    .push_res (res),
    .pop      (out_valid && out_ready),
    .head     (out_data),
    .not_empty(out_valid),
    .room2    (in_ready)
  );

endmodule

`default_nettype wire
